@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// ASSERT_AT checks a property on every rising clock edge outside reset.
// ASSERT_NEVER checks that a condition is never true outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

@@ rtl/dwg_pkg.sv @@
package dwg_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned PHASE_BITS_DEF  = 16;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned DAC_W    = 6;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned RAW_W    = 16;
  localparam int unsigned CSUM_W   = 8;

  localparam logic [STEP_W-1:0] TUNING_RESET = 16'd100;
  localparam logic [RAW_W-1:0]  LOAD_BIAS    = 16'd2048;

  // Triangle reset shape
  localparam int unsigned TRI_BASE = 1024;
  localparam int unsigned TRI_PEAK = 3072;
  localparam int unsigned TRI_SPAN = 2048;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2
  } opcode_e;

  typedef enum logic [0:0] {
    KIND_SAMPLE = 1'b0,
    KIND_ACK    = 1'b1
  } kind_e;

  typedef struct packed {
    opcode_e          opcode;
    logic [RAW_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [DAC_W-1:0]  dac_high;
    logic [DAC_W-1:0]  dac_low;
    logic [CSUM_W-1:0] load_checksum;
  } out_item_t;

  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] data;
  } tbl_wr_t;

  // Reset content of one table entry
  function automatic logic [SAMPLE_W-1:0] tri_sample(input int unsigned idx,
                                                     input int unsigned half,
                                                     input int unsigned step);
    int unsigned y;
    if (idx < half) begin
      y = TRI_BASE + idx * step;
    end else begin
      y = TRI_PEAK - (idx - half) * step;
    end
    return y[SAMPLE_W-1:0];
  endfunction

endpackage

@@ rtl/dwg_phase.sv @@
module dwg_phase import dwg_pkg::*; #(
  parameter int unsigned PHASE_BITS  = PHASE_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic [STEP_W-1:0] step_i,
  output logic [AW-1:0]     addr_o
);

  localparam int unsigned PW = PHASE_BITS + AW + 1;
  localparam int unsigned SW = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PW-1:0]         prod;
  logic [SW-1:0]         sum;

  // Scale phase onto the table range
  assign prod   = PW'(phase_q) * PW'(TABLE_DEPTH);
  assign addr_o = AW'(prod >> PHASE_BITS);

  assign sum     = SW'(phase_q) + SW'(step_i);
  assign phase_d = sum[PHASE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

@@ rtl/dwg_load.sv @@
module dwg_load import dwg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              load_i,
  input  logic [RAW_W-1:0]  sample_i,
  output tbl_wr_t           wr_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic              ack_o,
  output logic [CSUM_W-1:0] csum_o
);

  localparam int unsigned PTR_W = AW + 1;

  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [CSUM_W-1:0] csum_q, csum_d;
  logic [RAW_W-1:0]  biased;
  logic              full;

  assign full   = (ptr_q == PTR_W'(TABLE_DEPTH));
  assign biased = LOAD_BIAS - sample_i;

  assign wr_o.en   = load_i && !full;
  assign wr_o.data = biased[SAMPLE_W-1:0];
  assign wr_addr_o = ptr_q[AW-1:0];

  always_comb begin
    ptr_d  = ptr_q;
    csum_d = csum_q;
    if (start_i) begin
      ptr_d  = '0;
      csum_d = '0;
    end else if (wr_o.en) begin
      ptr_d  = ptr_q + PTR_W'(1);
      csum_d = csum_q ^ sample_i[RAW_W-1:CSUM_W] ^ sample_i[CSUM_W-1:0];
    end
  end

  // Last entry written: report the checksum including this sample
  assign ack_o  = wr_o.en && (ptr_q == PTR_W'(TABLE_DEPTH - 1));
  assign csum_o = csum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      csum_q <= '0;
    end else begin
      ptr_q  <= ptr_d;
      csum_q <= csum_d;
    end
  end

endmodule

@@ rtl/dwg_table.sv @@
module dwg_table import dwg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbl_wr_t             wr_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [SAMPLE_W-1:0] rd_sample_o
);

  localparam int unsigned FILL_W   = AW + 1;
  localparam int unsigned HALF     = TABLE_DEPTH / 2;
  localparam int unsigned TRI_STEP = TRI_SPAN / HALF;

  logic [SAMPLE_W-1:0] mem_q [TABLE_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] tri_q;
  logic                hit_q;
  logic [FILL_W-1:0]   fill_q;

  // Loads always run upward from entry zero, so the written entries form a
  // prefix; track its length instead of a valid bit per entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (wr_i.en && (FILL_W'(wr_addr_i) >= fill_q)) begin
      fill_q <= FILL_W'(wr_addr_i) + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
      tri_q     <= tri_sample(32'(rd_addr_i), HALF, TRI_STEP);
      hit_q     <= (FILL_W'(rd_addr_i) < fill_q);
    end
  end

  assign rd_sample_o = hit_q ? rd_data_q : tri_q;

endmodule

@@ rtl/dds_wavetable_generator_unit.sv @@
// DDS wave-table generator.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transfer per item;
//   OP_TICK emits one DAC sample, OP_LOAD writes the next table entry,
//   OP_START rewinds the load pointer and clears the checksum.
// Output channel (out_valid_o / out_stall_i / out_data_o): a sample on every
//   tick, and a checksum acknowledgement after the last table entry is loaded.
// Configuration: cfg_we_i writes cfg_wdata_i into the tuning step, the phase
//   increment per tick. Write it only while no item is in flight.
// Pipeline: the input transfer edge fills the read stage and the table read
//   register; the output register loads from them when it can advance, and
//   the result is offered on out_valid_o once it is in the output register.
// Throughput: one item per clock while in_stall_o is low; per item the table
//   does at most one write (load) or read (tick); a tick advances the phase.
// Reset: phase, load pointer and checksum clear, the tuning step returns to
//   100, and the table reads as a triangle wave until entries are loaded.
//   No clearing pass is needed, items are taken right after reset.
// Stall: a stalled output holds its result; one more result parks in the
//   read stage, after which in_stall_o rises until the output drains.
`include "assert_macros.svh"

module dds_wavetable_generator_unit import dwg_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int unsigned PHASE_BITS  = PHASE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [STEP_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [STEP_W-1:0]   step_q;
  logic                accept, is_tick, is_load, is_start;
  logic                out_adv, s1_adv;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [SAMPLE_W-1:0] rd_sample;
  tbl_wr_t             wr;
  logic                ack;
  logic [CSUM_W-1:0]   csum;

  // Read stage: result kind and checksum alongside the registered table read
  logic              s1_valid_q;
  kind_e             s1_kind_q;
  logic [CSUM_W-1:0] s1_csum_q;

  logic      out_valid_q;
  out_item_t out_q, out_d;

  // Tuning step register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= TUNING_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Handshake: advance each stage when the one after it can take data
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_tick  = accept && (in_data_i.opcode == OP_TICK);
  assign is_load  = accept && (in_data_i.opcode == OP_LOAD);
  assign is_start = accept && (in_data_i.opcode == OP_START);

  dwg_phase #(
    .PHASE_BITS  (PHASE_BITS),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (is_tick),
    .step_i (step_q),
    .addr_o (rd_addr)
  );

  dwg_load #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_load (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (is_start),
    .load_i    (is_load),
    .sample_i  (in_data_i.sample_value),
    .wr_o      (wr),
    .wr_addr_o (wr_addr),
    .ack_o     (ack),
    .csum_o    (csum)
  );

  dwg_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .rd_en_i     (is_tick),
    .rd_addr_i   (rd_addr),
    .rd_sample_o (rd_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= is_tick || ack;
    end
  end

  // Hold the read stage payload unless a new transfer lands
  always_ff @(posedge clk_i) begin
    if (s1_adv && accept) begin
      s1_kind_q <= ack ? KIND_ACK : KIND_SAMPLE;
      s1_csum_q <= csum;
    end
  end

  always_comb begin
    out_d.kind          = s1_kind_q;
    out_d.dac_high      = '0;
    out_d.dac_low       = '0;
    out_d.load_checksum = '0;
    unique case (s1_kind_q)
      KIND_SAMPLE: begin
        out_d.dac_high = rd_sample[SAMPLE_W-1:DAC_W];
        out_d.dac_low  = rd_sample[DAC_W-1:0];
      end
      KIND_ACK: begin
        out_d.load_checksum = s1_csum_q;
      end
      default: begin
        out_d.kind = KIND_SAMPLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stall toward the source only ever comes from a parked read stage
  `ASSERT_AT(a_stall_has_cause, clk_i, rst_ni, in_stall_o |-> s1_valid_q, "stall without parked item")
  // Read stage and output both full while the sink stalls must block input
  `ASSERT_AT(a_full_blocks, clk_i, rst_ni, (s1_valid_q && out_valid_q && out_stall_i) |-> in_stall_o, "input open with pipeline full")
  // Completing the last load puts an acknowledgement into the read stage
  `ASSERT_AT(a_ack_staged, clk_i, rst_ni, ack |=> (s1_valid_q && (s1_kind_q == KIND_ACK)), "load ack lost")
  // A tick and a table write never share one transfer
  `ASSERT_NEVER(a_rd_wr_excl, clk_i, rst_ni, is_tick && wr.en, "tick and load in same transfer")

endmodule
